@@ src/float_to_fill_pattern_core_defines.svh @@
// Assertion macros for the fill-pattern converter.
`ifndef FLOAT_TO_FILL_PATTERN_CORE_DEFINES_SVH
`define FLOAT_TO_FILL_PATTERN_CORE_DEFINES_SVH

// Implication check, disabled in reset.
`define FFP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication check, disabled in reset.
`define FFP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/ffp_pkg.sv @@
`default_nettype none
package ffp_pkg;

  typedef enum logic [2:0] {
    KIND_FP16  = 3'd0,
    KIND_BF16  = 3'd1,
    KIND_FP32  = 3'd2,
    KIND_INT32 = 3'd3,
    KIND_INT16 = 3'd4,
    KIND_UINT8 = 3'd5,
    KIND_INT8  = 3'd6
  } kind_t;

  localparam int unsigned WordW = 32;
  localparam int unsigned KindW = 3;
  localparam logic [15:0] Fp16Inf = 16'h7C00;
  localparam logic [7:0]  ExpBias = 8'd127;

endpackage
`default_nettype wire

@@ src/ffp_convert.sv @@
`default_nettype none
module ffp_convert
  import ffp_pkg::*;
(
  input  wire logic [31:0] value_bits,
  input  wire logic [2:0]  kind,
  output logic [31:0]      fill_word
);

  logic        sgn;
  logic [7:0]  ef;
  logic [22:0] mant;
  logic [23:0] m1;
  logic [15:0] h16;
  logic [15:0] b16;
  logic [15:0] hi;
  logic [15:0] lo;
  logic [31:0] i32;
  logic [31:0] mag;
  logic [4:0]  sub_sh;
  logic [4:0]  ish;

  assign sgn  = value_bits[31];
  assign ef   = value_bits[30:23];
  assign mant = value_bits[22:0];
  assign m1   = {1'b1, mant};
  assign hi   = value_bits[31:16];
  assign lo   = value_bits[15:0];
  // subnormal shift = -e - 1 = 126 - ef, ef in 103..112
  assign sub_sh = 5'(8'd126 - ef);
  assign ish    = 5'(ef - ExpBias);

  always_comb begin
    if (ef == 8'hFF) begin
      h16 = {sgn, 15'(Fp16Inf)} | {6'd0, mant[22:13]};
    end else if (ef >= 8'd143) begin
      h16 = {sgn, 15'(Fp16Inf)};
    end else if (ef >= 8'd113) begin
      h16 = {sgn, 5'(ef - 8'd112), mant[22:13]};
    end else if (ef >= 8'd103) begin
      h16 = {sgn, 15'(m1 >> sub_sh)};
    end else begin
      h16 = {sgn, 15'd0};
    end
  end

  always_comb begin
    if (lo > 16'h8000 || (lo == 16'h8000 && hi[0])) begin
      b16 = hi + 16'd1;
    end else begin
      b16 = hi;
    end
  end

  always_comb begin
    if (ef >= 8'd150) begin
      mag = {8'd0, m1} << (ef - 8'd150);
    end else begin
      mag = {8'd0, m1} >> (5'd23 - ish);
    end
    if (ef == 8'hFF && mant != 23'd0) begin
      i32 = 32'd0;
    end else if (ef < ExpBias) begin
      i32 = 32'd0;
    end else if (ef >= 8'd158) begin
      i32 = sgn ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      i32 = sgn ? (32'd0 - mag) : mag;
    end
  end

  always_comb begin
    case (kind)
      KIND_FP16:  fill_word = {h16, h16};
      KIND_BF16:  fill_word = {b16, b16};
      KIND_FP32:  fill_word = value_bits;
      KIND_INT32: fill_word = i32;
      KIND_INT16: fill_word = {i32[15:0], i32[15:0]};
      KIND_UINT8, KIND_INT8:
                  fill_word = {4{i32[7:0]}};
      default:    fill_word = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

@@ src/float_to_fill_pattern_core.sv @@
// Fill-pattern converter: takes fp32 bits and an element-type code, returns
// the converted element repeated across a 32-bit word. One beat per cycle
// while in_ready is high. An accepted beat is held in the input register
// and its result registered into the result register, or into the skid
// while the output stalls. A skid stage keeps in_ready up while one result
// waits; in_ready drops only while both the result and the skid are full.
`default_nettype none
module float_to_fill_pattern_core
  import ffp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] value_bits,
  input  wire logic [2:0]  kind,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      fill_word
);

  logic        s0_valid;
  logic [31:0] s0_value;
  logic [2:0]  s0_kind;
  logic [31:0] conv;
  logic        s0_adv;
  logic        skid_valid;
  logic [31:0] skid_word;

  ffp_convert u_conv (
    .value_bits(s0_value),
    .kind(s0_kind),
    .fill_word(conv)
  );

  // s0 can move on unless output is full and stalled
  assign s0_adv   = !out_valid || out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid   <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (s0_adv) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          fill_word  <= skid_word;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= s0_valid;
          fill_word <= conv;
        end
      end else if (s0_valid && !skid_valid) begin
        skid_valid <= 1'b1;
        skid_word  <= conv;
      end
      if (in_ready) begin
        s0_valid <= in_valid;
        s0_value <= value_bits;
        s0_kind  <= kind;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/ffp_checker.sv @@
`default_nettype none
`include "float_to_fill_pattern_core_defines.svh"
module ffp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] fill_word
);

  `FFP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(fill_word))
  `FFP_ASSERT_NXT(a_ready_drain, out_ready, in_ready)
  `FFP_ASSERT_NXT(a_idle_empty, !in_valid && !out_valid && in_ready, !out_valid || in_ready)

endmodule

bind float_to_fill_pattern_core ffp_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .fill_word(fill_word)
);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none
module tb_top;
  import ffp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] value_bits = '0;
  logic [2:0]  kind = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] fill_word;

  logic [31:0] pending_words[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          stall_enable = 1'b1;
  int          burst_left = 0;

  localparam int IdleLimit = 2000;

  float_to_fill_pattern_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .value_bits(value_bits), .kind(kind),
    .out_valid(out_valid), .out_ready(out_ready),
    .fill_word(fill_word)
  );

  always #4 clk = ~clk;

  function automatic logic [15:0] half_of(logic [31:0] u);
    logic [15:0] sgn;
    int          e;
    logic [23:0] m;
    sgn = {u[31], 15'd0};
    e = int'(u[30:23]) - 127;
    m = {1'b1, u[22:0]};
    if (e == 128) return sgn | Fp16Inf | 16'(u[22:13]);
    if (e >= 16) return sgn | Fp16Inf;
    if (e >= -14) return sgn | {1'b0, 5'(e + 15), u[22:13]};
    if (e >= -24) return sgn | 16'(m >> (-e - 1));
    return sgn;
  endfunction

  function automatic logic [15:0] brain_of(logic [31:0] u);
    logic [15:0] hi;
    hi = u[31:16];
    if (u[15:0] > 16'h8000 || (u[15:0] == 16'h8000 && hi[0])) hi = hi + 16'd1;
    return hi;
  endfunction

  function automatic logic [31:0] int_of(logic [31:0] u);
    logic [7:0]  ef;
    logic [31:0] mag;
    int          sh;
    ef = u[30:23];
    if (ef == 8'hFF && u[22:0] != 0) return 32'd0;
    if (ef < ExpBias) return 32'd0;
    if (ef >= ExpBias + 8'd31) return u[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sh = int'(ef) - 127;
    mag = {8'd0, 1'b1, u[22:0]};
    mag = (sh >= 23) ? (mag << (sh - 23)) : (mag >> (23 - sh));
    return u[31] ? -mag : mag;
  endfunction

  function automatic logic [31:0] fill_of(logic [31:0] u, logic [2:0] k);
    logic [15:0] h;
    logic [7:0]  b;
    case (k)
      KIND_FP16: begin h = half_of(u); return {h, h}; end
      KIND_BF16: begin h = brain_of(u); return {h, h}; end
      KIND_FP32: return u;
      KIND_INT32: return int_of(u);
      KIND_INT16: begin h = 16'(int_of(u)); return {h, h}; end
      KIND_UINT8, KIND_INT8: begin b = 8'(int_of(u)); return {4{b}}; end
      default: return 32'd0;
    endcase
  endfunction

  task automatic send_beat(logic [31:0] u, logic [2:0] k);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    value_bits <= u;
    kind <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_words.push_back(fill_of(u, k));
    burst_left--;
  endtask

  task automatic flush_beats();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("fill_word: unexpected beat %h", fill_word);
        errors++;
      end else begin
        logic [31:0] want;
        want = pending_words.pop_front();
        if (fill_word !== want) begin
          $error("fill_word: expected %h actual %h", want, fill_word);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!stall_enable) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 9) < 6);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("float_to_fill_pattern_core test failed");
      $finish;
    end
  end

  task automatic test_directed();
    logic [31:0] vals[$];
    vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
             32'h7FC0_0000, 32'h7F80_0001, 32'h4780_0000, 32'h477F_E000,
             32'h3880_0000, 32'h3380_0000, 32'h3300_0000, 32'h0000_0001,
             32'h3F80_8000, 32'h3F81_8000, 32'hFFFF_FFFF, 32'h4F00_0000,
             32'hCF00_0000, 32'hC2FF_FFFF, 32'h3F7F_FFFF, 32'h4B7F_FFFF};
    foreach (vals[i]) send_beat(vals[i], 3'(i % 8));
    for (int k = 0; k < 8; k++) send_beat(32'hC3A5_8000, 3'(k));
  endtask

  task automatic test_random_values();
    logic [31:0] u;
    for (int i = 0; i < 380; i++) begin
      u = $urandom();
      if ($urandom_range(0, 3) == 0) u[30:23] = 8'($urandom_range(100, 160));
      send_beat(u, 3'($urandom_range(0, 7)));
      if (i == 200) flush_beats();
    end
  endtask

  task automatic test_no_stall();
    stall_enable = 1'b0;
    burst_left = 40;
    for (int i = 0; i < 40; i++) send_beat($urandom(), 3'($urandom_range(0, 7)));
    stall_enable = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_values();
    test_no_stall();
    flush_beats();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("float_to_fill_pattern_core test passed");
    else $display("float_to_fill_pattern_core test failed");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+src
src/ffp_pkg.sv
src/ffp_convert.sv
src/float_to_fill_pattern_core.sv
src/ffp_checker.sv
tb/sv/tb_top.sv
